// ===== hdl/fca_pkg.sv =====
// ----------------------------------------------------------------------------
// fca_pkg
// Shared constants and types of the fixed cell allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int NUM_CELLS = 128;

  localparam int IDX_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CNT_W  = $clog2(NUM_CELLS + 1);
  localparam int ADDR_W = 48;
  localparam int SIZE_W = 21;
  localparam int OFF_W  = IDX_W + SIZE_W;
  localparam int STEP_W = $clog2(IDX_W + 1);

  localparam int GRP    = 8;
  localparam int NGRP   = (NUM_CELLS + GRP - 1) / GRP;
  localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int POS_W  = $clog2(GRP);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;

  localparam int REG_ZONE_BASE     = 0;
  localparam int REG_CELL_CAPACITY = 1;

  localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(4096);

  typedef struct packed {
    logic             done;
    logic             exact;
    logic [IDX_W-1:0] quot;
  } div_stat_t;

endpackage

// ===== hdl/fca_div.sv =====
// ----------------------------------------------------------------------------
// fca_div
// Restoring divider: offset by cell capacity, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fca_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fca_pkg::OFF_W-1:0]  dividend,
  input  logic [fca_pkg::SIZE_W-1:0] divisor,
  output fca_pkg::div_stat_t         stat
);

  logic [fca_pkg::OFF_W-1:0]  rem;
  logic [fca_pkg::OFF_W-1:0]  dvs;
  logic [fca_pkg::IDX_W-1:0]  quot;
  logic [fca_pkg::STEP_W-1:0] steps;
  logic                       busy;
  logic                       done;
  logic                       take;

  assign take = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= fca_pkg::STEP_W'(fca_pkg::IDX_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == fca_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dvs  <= fca_pkg::OFF_W'(divisor) << (fca_pkg::IDX_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (take) begin
        rem <= rem - dvs;
      end
      dvs  <= dvs >> 1;
      quot <= (quot << 1) | fca_pkg::IDX_W'(take);
    end
  end

  assign stat.done  = done;
  assign stat.exact = (rem == '0);
  assign stat.quot  = quot;

endmodule

// ===== hdl/fixed_cell_allocator_top.sv =====
// ----------------------------------------------------------------------------
// fixed_cell_allocator_top
// Allocator over a zone of equal cells: allocate, release, check address.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          content
//  s_*      in         tvalid/tready      request word (opcode, size, address)
//  m_*      out        tvalid/tready      result word (ok, address, size, counts)
//  apb      in         psel/penable       zone_base @0x0, cell_capacity @0x8
//
//  Allocate: the free-cell scan of the in-use bits checks groups of 8 cells
//  in turn, 16 groups for 128 cells, and stops at the first free cell.
//  Release/check: the bit-serial divider finds the cell index from the offset.
//  One request at a time; a new request is taken while a result waits.
//  Reset frees every cell at once through the in-use bits; no clearing pass.
// ----------------------------------------------------------------------------
module fixed_cell_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // req_size[20:0], address[68:21], zero pad
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // ok[0], cell_address[48:1], cell_size[69:49],
                                 // used_count[77:70], all_used[78], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_LOOK = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  state_t state;

  logic [fca_pkg::ADDR_W-1:0]    zone_base;
  logic [fca_pkg::SIZE_W-1:0]    cell_capacity;
  logic [fca_pkg::SIZE_W-1:0]    cap_eff;
  logic [fca_pkg::OFF_W-1:0]     limit;

  logic [1:0]                    op;
  logic [fca_pkg::SIZE_W-1:0]    req_size;
  logic [fca_pkg::ADDR_W-1:0]    off;
  logic                          below;
  logic [fca_pkg::IDX_W-1:0]     idx;
  logic [fca_pkg::OFF_W-1:0]     prod;
  logic [fca_pkg::GRP_W-1:0]     grp;
  logic                          res_ok;
  logic                          res_alloc;
  logic                          chk_read;

  logic [fca_pkg::NUM_CELLS-1:0] used;
  logic [fca_pkg::CNT_W-1:0]     cnt;

  logic [fca_pkg::NGRP*fca_pkg::GRP-1:0] used_pad;
  logic [fca_pkg::GRP-1:0]       grp_bits;
  logic                          free_hit;
  logic [fca_pkg::POS_W-1:0]     free_pos;
  logic [fca_pkg::IDX_W-1:0]     idx_found;

  logic [fca_pkg::SIZE_W-1:0]    mem [fca_pkg::NUM_CELLS];
  logic [fca_pkg::SIZE_W-1:0]    rd_data;
  logic                          mem_we;
  logic                          mem_re;

  logic                          div_start;
  fca_pkg::div_stat_t            div_stat;

  logic                          cfg_we;
  logic                          accept;
  logic                          out_load;
  logic                          look_hit;

  assign pready   = 1'b1;
  assign cfg_we   = psel & penable & pwrite & pready;
  assign prdata   = paddr[3] ? 64'(cell_capacity) : 64'(zone_base);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;

  assign cap_eff  = (cell_capacity == '0) ? fca_pkg::SIZE_W'(1) : cell_capacity;
  assign limit    = fca_pkg::OFF_W'(cap_eff) * fca_pkg::OFF_W'(fca_pkg::NUM_CELLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_base     <= '0;
      cell_capacity <= fca_pkg::CAP_RESET;
    end else if (cfg_we) begin
      if (paddr[3]) begin
        cell_capacity <= pwdata[fca_pkg::SIZE_W-1:0];
      end else begin
        zone_base <= pwdata[fca_pkg::ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    used_pad = {(fca_pkg::NGRP*fca_pkg::GRP){1'b1}};
    used_pad[fca_pkg::NUM_CELLS-1:0] = used;
    grp_bits = used_pad[grp*fca_pkg::GRP +: fca_pkg::GRP];
    free_hit = ~&grp_bits;
    free_pos = '0;
    for (int i = fca_pkg::GRP - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        free_pos = fca_pkg::POS_W'(i);
      end
    end
    idx_found = fca_pkg::IDX_W'({grp, free_pos});
  end

  assign mem_we    = (state == S_SCAN) && free_hit;
  assign look_hit  = (state == S_LOOK) && used[idx];
  assign mem_re    = look_hit && (op == fca_pkg::OP_CHECK);
  assign div_start = (state == S_PREP) && (op == fca_pkg::OP_RELEASE ||
                     op == fca_pkg::OP_CHECK) && !below && (off < 48'(limit));
  assign out_load  = (state == S_RESP) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_found] <= req_size;
    end
    if (mem_re) begin
      rd_data <= mem[idx];
    end
  end

  fca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (off[fca_pkg::OFF_W-1:0]),
    .divisor  (cap_eff),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (op == fca_pkg::OP_ALLOC && req_size != '0) begin
            state <= S_SCAN;
          end else if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= S_RESP;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= div_stat.exact ? S_LOOK : S_RESP;
          end
        end
        S_LOOK: begin
          if (look_hit && op == fca_pkg::OP_RELEASE) begin
            used[idx] <= 1'b0;
            cnt       <= cnt - 1'b1;
          end
          state <= S_RESP;
        end
        S_SCAN: begin
          if (free_hit) begin
            used[idx_found] <= 1'b1;
            cnt             <= cnt + 1'b1;
            state           <= S_MUL;
          end else if (grp == fca_pkg::GRP_W'(fca_pkg::NGRP - 1)) begin
            state <= S_RESP;
          end
        end
        S_MUL: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= s_tuser;
      req_size  <= s_tdata[20:0];
      off       <= s_tdata[68:21] - zone_base;
      below     <= (s_tdata[68:21] < zone_base);
      grp       <= '0;
      res_ok    <= 1'b0;
      res_alloc <= 1'b0;
      chk_read  <= 1'b0;
    end
    if (state == S_DIV && div_stat.done) begin
      idx <= div_stat.quot;
    end
    if (state == S_LOOK) begin
      res_ok   <= look_hit;
      chk_read <= mem_re;
    end
    if (state == S_SCAN) begin
      grp <= grp + 1'b1;
      if (free_hit) begin
        idx       <= idx_found;
        res_ok    <= 1'b1;
        res_alloc <= 1'b1;
      end
    end
    if (state == S_MUL) begin
      prod <= fca_pkg::OFF_W'(idx) * fca_pkg::OFF_W'(cap_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[0]     <= res_ok;
      m_tdata[48:1]  <= res_alloc ? zone_base + 48'(prod) : '0;
      m_tdata[69:49] <= chk_read ? rd_data : '0;
      m_tdata[77:70] <= 8'(cnt);
      m_tdata[78]    <= (cnt == fca_pkg::CNT_W'(fca_pkg::NUM_CELLS));
      m_tdata[79]    <= 1'b0;
    end
  end

endmodule
